FILE: design/oled_shadow_buffer_writer_macros.svh
// Assertion macros for the OLED shadow buffer writer.
`ifndef OLED_SHADOW_BUFFER_WRITER_MACROS_SVH
`define OLED_SHADOW_BUFFER_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define OSBW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition that must never be true outside reset.
`define OSBW_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define OSBW_ASSERT(label, prop, msg)
`define OSBW_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: design/osbw_pkg.sv
// Shared constants, types and helpers of the OLED shadow buffer writer.
package osbw_pkg;

   // Display geometry.
   localparam int PAGE_COUNT   = 8;
   localparam int COLUMN_COUNT = 128;

   // Shadow store geometry.
   localparam int STORE_DEPTH  = PAGE_COUNT * COLUMN_COUNT;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

   // Cursor widths: wide enough for the request fields and for the geometry.
   localparam int PAGE_W = ($clog2(PAGE_COUNT) > 3) ? $clog2(PAGE_COUNT) : 3;
   localparam int COL_W  = ($clog2(COLUMN_COUNT) > 7) ? $clog2(COLUMN_COUNT) : 7;

   // Action codes.
   localparam logic [1:0] ACT_SET_CURSOR = 2'd0;
   localparam logic [1:0] ACT_WRITE_DATA = 2'd1;
   localparam logic [1:0] ACT_DRAW_POINT = 2'd2;

   // Controller command bases.
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;

   // Write port of the shadow store.
   typedef struct packed {
      logic                    en;
      logic [STORE_ADDR_W-1:0] addr;
      logic [7:0]              data;
   } store_wr_type;

   // Linear store address of a page and column.
   function automatic logic [STORE_ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] pg,
                                                          input logic [COL_W-1:0]  col);
      int lin;
      lin = int'(pg) * COLUMN_COUNT + int'(col);
      return STORE_ADDR_W'(lin);
   endfunction

   // Column advance, wrapping to zero at the column count.
   function automatic logic [COL_W-1:0] col_advance(input logic [COL_W-1:0] col);
      logic [COL_W:0] nxt;
      nxt = {1'b0, col} + {{COL_W{1'b0}}, 1'b1};
      if (int'(nxt) >= COLUMN_COUNT) begin
         return '0;
      end
      return nxt[COL_W-1:0];
   endfunction

endpackage

FILE: design/oled_shadow_buffer_writer.sv
// Top level: request decode, cursor, byte sequencer and result register.
// After accept, the first byte of a request goes into the result register once that register is free.
// Bytes per request: set cursor emits three commands, write data one data byte, draw point both.
// Ignored requests (unused action, point outside) emit nothing.
// The byte sequencer sets the rate; the next request is taken as the last byte is registered.
// After reset a clearing pass zeroes all 1024 entries of the shadow store; req_ready is low meanwhile.
module oled_shadow_buffer_writer
   import osbw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [2:0] req_page,
   input  logic [6:0] req_column,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_point_x,
   input  logic [7:0] req_point_y,
   input  logic       req_pixel_on,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_command,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

`include "oled_shadow_buffer_writer_macros.svh"

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [1:0]        idx_ff;
   logic [PAGE_W-1:0] cursor_page_ff;
   logic [COL_W-1:0]  cursor_column_ff;
   logic [1:0]        job_action_ff;
   logic [PAGE_W-1:0] job_page_ff;
   logic [COL_W-1:0]  job_col_ff;
   logic [7:0]        job_data_ff;
   logic [2:0]        job_bit_ff;
   logic              job_on_ff;
   logic              rsp_valid_ff;
   logic              rsp_is_command_ff;
   logic [7:0]        rsp_out_byte_ff;
   logic              rsp_last_ff;

   logic              req_fire;
   logic              pt_ok;
   logic [PAGE_W-1:0] pt_page;
   logic [COL_W-1:0]  pt_col;
   logic              go;
   logic [PAGE_W-1:0] tgt_page;
   logic [COL_W-1:0]  tgt_col;
   logic [COL_W-1:0]  cursor_col_in;
   logic [1:0]        idx_start;

   logic [7:0]        rd_data;
   logic              clear_busy;
   logic [7:0]        pix_mask;
   logic [7:0]        pix_byte;
   logic [7:0]        data_byte;
   logic [7:0]        emit_byte;
   logic              emit_cmd;
   logic              emit_last;
   logic              emit_load;
   logic              job_in_store;
   store_wr_type      store_wr;

   assign req_fire = req_valid && req_ready;

   // Point decode: page from the upper row bits, bit from the lower three.
   assign pt_ok   = (int'(req_point_x) < COLUMN_COUNT) && (int'(req_point_y) < 8 * PAGE_COUNT);
   assign pt_page = PAGE_W'(req_point_y >> 3);
   assign pt_col  = COL_W'(req_point_x);

   // Request decode: target cursor, first byte index and the new cursor column.
   always_comb begin
      go            = 1'b0;
      tgt_page      = cursor_page_ff;
      tgt_col       = cursor_column_ff;
      idx_start     = 2'd0;
      cursor_col_in = cursor_column_ff;
      case (req_action)
         ACT_SET_CURSOR: begin
            go            = 1'b1;
            tgt_page      = PAGE_W'(req_page);
            tgt_col       = COL_W'(req_column);
            cursor_col_in = COL_W'(req_column);
         end
         ACT_WRITE_DATA: begin
            go            = 1'b1;
            idx_start     = 2'd3;
            cursor_col_in = col_advance(cursor_column_ff);
         end
         ACT_DRAW_POINT: begin
            go            = pt_ok;
            tgt_page      = pt_page;
            tgt_col       = pt_col;
            cursor_col_in = col_advance(pt_col);
         end
         default: begin
            go = 1'b0;
         end
      endcase
   end

   // Read-modify-write of the pixel byte fetched at accept.
   assign pix_mask  = 8'h01 << job_bit_ff;
   assign pix_byte  = job_on_ff ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
   assign data_byte = (job_action_ff == ACT_DRAW_POINT) ? pix_byte : job_data_ff;

   // Byte selection: three cursor commands, then the data byte.
   always_comb begin
      case (idx_ff)
         2'd0:    emit_byte = CMD_PAGE_BASE | (8'(job_page_ff) & 8'h0F);
         2'd1:    emit_byte = CMD_COL_HIGH | ((8'(job_col_ff) & 8'hF0) >> 4);
         2'd2:    emit_byte = CMD_COL_LOW | (8'(job_col_ff) & 8'h0F);
         default: emit_byte = data_byte;
      endcase
   end

   assign emit_cmd  = (idx_ff != 2'd3);
   assign emit_last = (idx_ff == 2'd3) || ((idx_ff == 2'd2) && (job_action_ff == ACT_SET_CURSOR));
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = !clear_busy && ((state_ff == ST_IDLE) || (emit_load && emit_last));

   // Store the data byte when it is emitted, if the cursor lies inside the store.
   assign job_in_store  = (int'(job_page_ff) < PAGE_COUNT) && (int'(job_col_ff) < COLUMN_COUNT);
   assign store_wr.en   = emit_load && (idx_ff == 2'd3) && job_in_store;
   assign store_wr.addr = store_addr(job_page_ff, job_col_ff);
   assign store_wr.data = data_byte;

   osbw_frame_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (store_wr),
      .rd_en      (req_fire),
      .rd_addr    (store_addr(pt_page, pt_col)),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   // Sequencer state, cursor, request register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         idx_ff           <= 2'd0;
         cursor_page_ff   <= '0;
         cursor_column_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff      <= 1'b1;
            rsp_is_command_ff <= emit_cmd;
            rsp_out_byte_ff   <= emit_byte;
            rsp_last_ff       <= emit_last;
            idx_ff            <= idx_ff + 2'd1;
            if (emit_last) begin
               state_ff <= ST_IDLE;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            job_action_ff <= req_action;
            job_page_ff   <= tgt_page;
            job_col_ff    <= tgt_col;
            job_data_ff   <= req_data_byte;
            job_bit_ff    <= req_point_y[2:0];
            job_on_ff     <= req_pixel_on;
            if (go) begin
               state_ff         <= ST_EMIT;
               idx_ff           <= idx_start;
               cursor_page_ff   <= tgt_page;
               cursor_column_ff <= cursor_col_in;
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_command = rsp_is_command_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_last       = rsp_last_ff;

   // Checks on the sequencer and the store.
   `OSBW_ASSERT_NEVER(a_no_accept_while_clearing, clear_busy && req_ready, "request taken during clear")
   `OSBW_ASSERT(a_data_is_last, rsp_valid && !rsp_is_command |-> rsp_last, "data byte not last")
   `OSBW_ASSERT(a_write_on_data, store_wr.en |-> emit_load && !emit_cmd, "store write off data")
   `OSBW_ASSERT_NEVER(a_emit_after_clear, (state_ff == ST_EMIT) && clear_busy, "emit during clear")

endmodule

FILE: design/osbw_frame_store.sv
// Shadow frame store: single-port write, registered read, clearing sweep after reset.
module osbw_frame_store
   import osbw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  store_wr_type            wr,
   input  logic                    rd_en,
   input  logic [STORE_ADDR_W-1:0] rd_addr,
   output logic [7:0]              rd_data,
   output logic                    clear_busy
);

   logic [7:0]              mem [STORE_DEPTH];
   logic [STORE_ADDR_W-1:0] clr_addr_ff;
   logic [STORE_ADDR_W-1:0] clr_addr_in;
   logic                    clr_busy_ff;
   logic                    clr_busy_in;
   logic [7:0]              rd_data_ff;

   // Clearing sweep: one entry per cycle from address zero up.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + STORE_ADDR_W'(1);
         if (clr_addr_ff == STORE_ADDR_W'(STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Memory write: the sweep has priority over normal writes.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read; a write to the same address in the same cycle is forwarded.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

FILE: tb/tb_oled_shadow_buffer_writer.sv
// Self-checking testbench for the OLED shadow buffer writer: store prediction and byte checks.
module tb_oled_shadow_buffer_writer
   import osbw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any handshake before the run is declared hung.
   // This covers the clearing pass after reset.
   localparam int HANG_LIMIT    = 4000;
   // Cycles to wait after the last expected byte, to catch stray results.
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_ITEMS  = 235;

   // One byte sent to the display controller.
   typedef struct packed {
      logic       is_command;
      logic [7:0] out_byte;
      logic       last;
   } display_byte_type;

   // Shadow of the display memory and cursor, with the bytes still to arrive.
   class display_scoreboard;
      logic [7:0]       shadow [PAGE_COUNT*COLUMN_COUNT];
      int               cur_page;
      int               cur_col;
      display_byte_type pending_bytes [$];
      int               errors;

      function new();
         foreach (shadow[i]) shadow[i] = 8'h00;
         cur_page = 0;
         cur_col  = 0;
         errors   = 0;
      endfunction

      function int outstanding();
         return pending_bytes.size();
      endfunction

      function void push_byte(logic is_cmd, logic [7:0] value, logic ends_request);
         display_byte_type b;
         b.is_command = is_cmd;
         b.out_byte   = value;
         b.last       = ends_request;
         pending_bytes.push_back(b);
      endfunction

      // Move the cursor and queue the three positioning commands.
      function void load_cursor(int pg, int col, logic ends_request);
         cur_page = pg;
         cur_col  = col;
         push_byte(1'b1, CMD_PAGE_BASE | 8'(pg & 15), 1'b0);
         push_byte(1'b1, CMD_COL_HIGH | 8'((col >> 4) & 15), 1'b0);
         push_byte(1'b1, CMD_COL_LOW | 8'(col & 15), ends_request);
      endfunction

      // Store a byte at the cursor, queue it as data and advance the column.
      function void write_at_cursor(logic [7:0] value);
         if (cur_page < PAGE_COUNT && cur_col < COLUMN_COUNT) begin
            shadow[cur_page*COLUMN_COUNT + cur_col] = value;
         end
         push_byte(1'b0, value, 1'b1);
         cur_col = (cur_col + 1 >= COLUMN_COUNT) ? 0 : cur_col + 1;
      endfunction

      // Work out the bytes that an accepted request causes.
      function void note_request(logic [1:0] action, logic [2:0] page, logic [6:0] column,
                                 logic [7:0] data_byte, logic [7:0] point_x,
                                 logic [7:0] point_y, logic pixel_on);
         int         idx;
         logic [7:0] mask;
         case (action)
            ACT_SET_CURSOR: begin
               load_cursor(int'(page), int'(column), 1'b1);
            end
            ACT_WRITE_DATA: begin
               write_at_cursor(data_byte);
            end
            ACT_DRAW_POINT: begin
               // Points off the display are dropped without output.
               if (int'(point_x) < COLUMN_COUNT && int'(point_y) < 8*PAGE_COUNT) begin
                  idx  = int'(point_y >> 3) * COLUMN_COUNT + int'(point_x);
                  mask = 8'h01 << point_y[2:0];
                  shadow[idx] = pixel_on ? (shadow[idx] | mask) : (shadow[idx] & ~mask);
                  load_cursor(int'(point_y >> 3), int'(point_x), 1'b0);
                  write_at_cursor(shadow[idx]);
               end
            end
            default: begin
               // The unused action is ignored.
            end
         endcase
      endfunction

      // Compare one accepted byte with the oldest expectation.
      function void check_response(logic is_cmd, logic [7:0] value, logic last);
         display_byte_type want;
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected result is_command=%b out_byte=%h last=%b",
                     $time, is_cmd, value, last);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         if (is_cmd !== want.is_command) begin
            $display("%0t: is_command mismatch: expected %b actual %b",
                     $time, want.is_command, is_cmd);
            errors++;
         end
         if (value !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h actual %h",
                     $time, want.out_byte, value);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_action = '0;
   logic [2:0] req_page = '0;
   logic [6:0] req_column = '0;
   logic [7:0] req_data_byte = '0;
   logic [7:0] req_point_x = '0;
   logic [7:0] req_point_y = '0;
   logic       req_pixel_on = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_command;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   display_scoreboard sb = new();

   oled_shadow_buffer_writer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_page       (req_page),
      .req_column     (req_column),
      .req_data_byte  (req_data_byte),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_pixel_on   (req_pixel_on),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_command (rsp_is_command),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // Handshake monitor: check results first, then predict from the accepted request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_is_command, rsp_out_byte, rsp_last);
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_action, req_page, req_column, req_data_byte,
                            req_point_x, req_point_y, req_pixel_on);
         end
      end
   end

   // Receiver stall pattern: rsp_ready follows a stall mode that is redrawn at random.
   int ready_cycle = 0;
   int stall_mode  = 0;
   always @(posedge clock) begin
      ready_cycle++;
      if (ready_cycle % 50 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (ready_cycle % 3 == 0);
      endcase
   end

   // Watchdog on cycles with no handshake at all.
   int hung_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         hung_cycles = 0;
      end else begin
         hung_cycles++;
         if (hung_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Present one request and hold it until it is accepted.
   task automatic send_request(logic [1:0] action, logic [2:0] page, logic [6:0] column,
                               logic [7:0] data_byte, logic [7:0] point_x,
                               logic [7:0] point_y, logic pixel_on);
      req_valid     <= 1'b1;
      req_action    <= action;
      req_page      <= page;
      req_column    <= column;
      req_data_byte <= data_byte;
      req_point_x   <= point_x;
      req_point_y   <= point_y;
      req_pixel_on  <= pixel_on;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid for a number of cycles.
   task automatic sender_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random request: row fills after a cursor move, point draws, and some noise.
   int fill_left = 0;
   task automatic send_random(output logic counted);
      logic [1:0] action;
      logic [7:0] px;
      logic [7:0] py;
      int         pick;
      action  = ACT_WRITE_DATA;
      px      = 8'($urandom);
      py      = 8'($urandom);
      counted = 1'b1;
      pick    = $urandom_range(0, 99);
      if (fill_left > 0) begin
         fill_left--;
      end else if (pick < 20) begin
         action    = ACT_SET_CURSOR;
         fill_left = $urandom_range(0, 8);
      end else if (pick < 40) begin
         action = ACT_WRITE_DATA;
      end else if (pick < 65) begin
         // Small corner, so that draws revisit the same bytes.
         action = ACT_DRAW_POINT;
         px     = 8'($urandom_range(0, 7));
         py     = 8'($urandom_range(0, 15));
      end else if (pick < 88) begin
         action = ACT_DRAW_POINT;
         px     = 8'($urandom_range(0, COLUMN_COUNT - 1));
         py     = 8'($urandom_range(0, 8*PAGE_COUNT - 1));
      end else if (pick < 95) begin
         action  = ACT_DRAW_POINT;
         counted = 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            px = 8'($urandom_range(COLUMN_COUNT, 255));
         end else begin
            py = 8'($urandom_range(8*PAGE_COUNT, 255));
         end
      end else begin
         action  = ~2'b00;
         counted = 1'b0;
      end
      send_request(action, 3'($urandom), 7'($urandom), 8'($urandom), px, py, 1'($urandom));
   endtask

   // Stimulus: reset, directed corner cases, then random bursts.
   initial begin
      int   sent;
      int   burst;
      logic counted;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Cursor extremes, data extremes and the column wrap.
      send_request(ACT_SET_CURSOR, 3'd0, 7'd0, 8'h00, 8'd0, 8'd0, 1'b0);
      send_request(ACT_WRITE_DATA, 3'd7, 7'd127, 8'hA5, 8'd255, 8'd255, 1'b1);
      send_request(ACT_SET_CURSOR, 3'd7, 7'd127, 8'hFF, 8'd0, 8'd0, 1'b0);
      send_request(ACT_WRITE_DATA, 3'd0, 7'd0, 8'hFF, 8'd0, 8'd0, 1'b0);
      send_request(ACT_WRITE_DATA, 3'd0, 7'd0, 8'h5A, 8'd0, 8'd0, 1'b0);
      send_request(ACT_WRITE_DATA, 3'd0, 7'd0, 8'h00, 8'd0, 8'd0, 1'b0);
      // Point draws at the display corners, on and off.
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd0, 8'd0, 1'b1);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd127, 8'd63, 1'b1);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd127, 8'd63, 1'b0);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd0, 8'd7, 1'b1);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd0, 8'd0, 1'b0);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd0, 8'd0, 1'b0);
      // Points off the display and the unused action produce nothing.
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd128, 8'd0, 1'b1);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd0, 8'd64, 1'b1);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd255, 8'd255, 1'b1);
      send_request(~2'b00, 3'd7, 7'd127, 8'hFF, 8'd0, 8'd0, 1'b1);
      // Write after a draw lands one column right of the point.
      send_request(ACT_WRITE_DATA, 3'd0, 7'd0, 8'h81, 8'd0, 8'd0, 1'b0);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd64, 8'd35, 1'b1);
      send_request(ACT_DRAW_POINT, 3'd0, 7'd0, 8'h00, 8'd64, 8'd36, 1'b1);
      send_request(ACT_SET_CURSOR, 3'd3, 7'h55, 8'h00, 8'd0, 8'd0, 1'b0);
      send_request(ACT_WRITE_DATA, 3'd0, 7'd0, 8'h00, 8'd0, 8'd0, 1'b0);
      sender_gap(3);

      // Random bursts with random gaps; gaps of zero give back-to-back stretches.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            send_random(counted);
            if (counted) sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            sender_gap($urandom_range(1, 6));
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow stray results to show up.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
